/* rtl/fchc_pkg.sv */
package fchc_pkg;

    localparam int TEMP_W   = 12;
    localparam int PCT_W    = 7;
    localparam int SEG_W    = 4;
    localparam int REASON_W = 3;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    typedef logic [TEMP_W-1:0]   temp_t;
    typedef logic [7:0]          duty_t;
    typedef logic [REASON_W-1:0] reason_t;

    localparam reason_t REASON_ACTIVE      = 3'd0;
    localparam reason_t REASON_BELOW       = 3'd1;
    localparam reason_t REASON_ABOVE       = 3'd2;
    localparam reason_t REASON_HOLD        = 3'd3;
    localparam reason_t REASON_INVALID     = 3'd4;
    localparam reason_t REASON_IMPLAUSIBLE = 3'd5;

    localparam logic [CFG_AW-1:0] CFG_CURVE_TEMPS   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_CURVE_FANS    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MIN_FAN_PCT   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_HYSTERESIS    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_FALLBACK_PCT  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_PLAUSIBLE_MAX = 3'd5;

    localparam logic [31:0] CURVE_TEMPS_RST = 32'd1077556269;
    localparam logic [31:0] CURVE_FANS_RST  = 32'd1682320665;
    localparam logic [6:0]  FALLBACK_RST    = 7'd100;
    localparam temp_t       PLAUSIBLE_RST   = 12'd2400;

    localparam logic [SEG_W-1:0] SEG_NONE = 4'hF;

endpackage

/* rtl/fan_curve_hysteresis_controller.sv */
// Invalid, implausible, below and above samples go from S_EVAL straight to S_APPLY; a
// sample in curve segment j is scanned point by point in S_SCAN, then goes through the shared
// multiplier (S_MUL_A, S_MUL_B) and the restoring divider (S_DIV). A new sample is not taken
// before the last one is through: s_tready is low while a sample is in work, also while it
// waits in S_APPLY for the previous result beat to be taken. aresetn (synchronous, active low)
// loads the register defaults and clears the hysteresis state and the output beat.
module fan_curve_hysteresis_controller #(
    parameter int CURVE_POINTS = 4,
    parameter int FAN_MAX_PCT  = 100,
    parameter int HYST_MAX_DEG = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [11:0] temperature
    input  logic [0:0]                      s_tuser,   // [0] temp_ok
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [6:0] req_duty, [13:7] drv_duty
    output logic [7:0]                      m_tuser,   // [3:0] segment, [6:4] reason, [7] holding
    input  logic                            cfg_we,
    input  logic [fchc_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [fchc_pkg::CFG_DW-1:0]     cfg_wdata
);

    localparam int IDX_W = (CURVE_POINTS > 2) ? $clog2(CURVE_POINTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CURVE_POINTS - 1);
    localparam logic [3:0]       SEG_ABOVE = 4'(CURVE_POINTS);
    localparam logic [7:0]       FAN_MAX   = 8'(FAN_MAX_PCT);
    localparam logic [7:0]       HYST_MAX  = 8'(HYST_MAX_DEG);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MUL_A = 3'd3;
    localparam logic [2:0] S_MUL_B = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_APPLY = 3'd6;

    function automatic logic [7:0] point_byte(input logic [31:0] r, input logic [IDX_W-1:0] i);
        logic [3:0] w;
        w = 4'(i);
        case (w)
            4'd0:    return r[7:0];
            4'd1:    return r[15:8];
            4'd2:    return r[23:16];
            4'd3:    return r[31:24];
            default: return 8'd0;
        endcase
    endfunction

    // configuration
    logic [31:0]           curve_temps_reg;
    logic [31:0]           curve_fans_reg;
    logic [7:0]            min_fan_reg;
    logic [7:0]            hyst_deg_reg;
    logic [6:0]            fallback_reg;
    fchc_pkg::temp_t       plaus_max_reg;

    // hysteresis state
    logic                  has_applied_reg, has_applied_next;
    fchc_pkg::temp_t       last_temp_reg, last_temp_next;
    fchc_pkg::duty_t       held_reg, held_next;

    // sequencer and datapath
    logic [2:0]            state_reg, state_next;
    fchc_pkg::temp_t       t_reg, t_next;
    logic                  ok_reg, ok_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [3:0]            seg_reg, seg_next;
    fchc_pkg::reason_t     reason_reg, reason_next;
    fchc_pkg::duty_t       pct_reg, pct_next;
    logic [11:0]           den_reg, den_next;
    logic [11:0]           off_reg, off_next;
    logic [7:0]            p0_reg, p0_next;
    logic signed [8:0]     dp_reg, dp_next;
    logic [21:0]           acc_reg, acc_next;
    logic [12:0]           div_reg, div_next;
    logic [2:0]            k_reg, k_next;
    logic [7:0]            q_reg, q_next;

    // result beat
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [15:0]           m_tdata_reg, m_tdata_next;
    logic [7:0]            m_tuser_reg, m_tuser_next;

    // shared multiplier
    logic [11:0]           mul_a;
    logic signed [8:0]     mul_b;
    logic signed [21:0]    prod;
    logic [21:0]           prod_u;

    logic [21:0]           div_shift;
    logic                  div_ge;
    logic [7:0]            t_lo, t_hi, p_lo, p_hi;
    logic [7:0]            minp, hyst;
    fchc_pkg::duty_t       req, app;
    logic                  hold;
    fchc_pkg::reason_t     reason_out;
    logic                  out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign mul_a  = (state_reg == S_MUL_A) ? den_reg : off_reg;
    assign mul_b  = (state_reg == S_MUL_A) ? $signed({1'b0, p0_reg}) : dp_reg;
    assign prod   = 22'($signed({1'b0, mul_a}) * mul_b);
    assign prod_u = prod;

    assign div_shift = {9'd0, div_reg} << k_reg;
    assign div_ge    = (acc_reg >= div_shift);

    assign minp     = (min_fan_reg > FAN_MAX) ? FAN_MAX : min_fan_reg;
    assign hyst     = (hyst_deg_reg > HYST_MAX) ? HYST_MAX : hyst_deg_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next       = state_reg;
        t_next           = t_reg;
        ok_next          = ok_reg;
        idx_next         = idx_reg;
        seg_next         = seg_reg;
        reason_next      = reason_reg;
        pct_next         = pct_reg;
        den_next         = den_reg;
        off_next         = off_reg;
        p0_next          = p0_reg;
        dp_next          = dp_reg;
        acc_next         = acc_reg;
        div_next         = div_reg;
        k_next           = k_reg;
        q_next           = q_reg;
        has_applied_next = has_applied_reg;
        last_temp_next   = last_temp_reg;
        held_next        = held_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        t_lo             = point_byte(curve_temps_reg, idx_reg - 1'b1);
        t_hi             = point_byte(curve_temps_reg, idx_reg);
        p_lo             = point_byte(curve_fans_reg, idx_reg - 1'b1);
        p_hi             = point_byte(curve_fans_reg, idx_reg);
        req              = pct_reg;
        app              = pct_reg;
        hold             = 1'b0;
        reason_out       = reason_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    t_next     = s_tdata[11:0];
                    ok_next    = s_tuser[0];
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_APPLY;
                seg_next   = fchc_pkg::SEG_NONE;
                if (!ok_reg || t_reg == '0) begin
                    reason_next = fchc_pkg::REASON_INVALID;
                end else if (t_reg > plaus_max_reg) begin
                    reason_next = fchc_pkg::REASON_IMPLAUSIBLE;
                end else if (t_reg < {point_byte(curve_temps_reg, '0), 4'd0}) begin
                    seg_next    = 4'd0;
                    pct_next    = point_byte(curve_fans_reg, '0);
                    reason_next = fchc_pkg::REASON_BELOW;
                end else if (t_reg >= {point_byte(curve_temps_reg, LAST_IDX), 4'd0}) begin
                    seg_next    = SEG_ABOVE;
                    pct_next    = point_byte(curve_fans_reg, LAST_IDX);
                    reason_next = fchc_pkg::REASON_ABOVE;
                end else begin
                    idx_next    = IDX_W'(1);
                    reason_next = fchc_pkg::REASON_ACTIVE;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (t_reg < {t_hi, 4'd0}) begin
                    seg_next   = 4'(idx_reg);
                    den_next   = {t_hi - t_lo, 4'd0};
                    off_next   = t_reg - {t_lo, 4'd0};
                    p0_next    = p_lo;
                    dp_next    = $signed({1'b0, p_hi}) - $signed({1'b0, p_lo});
                    div_next   = {t_hi - t_lo, 5'd0};
                    state_next = S_MUL_A;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_MUL_A: begin
                acc_next   = {prod_u[20:0], 1'b0} + {10'd0, den_reg};
                state_next = S_MUL_B;
            end
            S_MUL_B: begin
                acc_next   = acc_reg + {prod_u[20:0], 1'b0};
                k_next     = 3'd7;
                q_next     = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_ge) begin
                    acc_next = acc_reg - div_shift;
                end
                q_next         = q_reg;
                q_next[k_reg]  = div_ge;
                k_next         = k_reg - 1'b1;
                if (k_reg == 3'd0) begin
                    pct_next   = q_next;
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    case (reason_reg)
                        fchc_pkg::REASON_INVALID: begin
                            req              = {1'b0, fallback_reg};
                            app              = {1'b0, fallback_reg};
                            has_applied_next = 1'b0;
                            last_temp_next   = '0;
                            held_next        = '0;
                        end
                        fchc_pkg::REASON_IMPLAUSIBLE: begin
                            req              = FAN_MAX;
                            app              = FAN_MAX;
                            has_applied_next = 1'b1;
                            last_temp_next   = t_reg;
                            held_next        = FAN_MAX;
                        end
                        default: begin
                            req = pct_reg;
                            if (req < minp) begin
                                req = minp;
                            end
                            if (req > FAN_MAX) begin
                                req = FAN_MAX;
                            end
                            app = req;
                            if (!has_applied_reg || req >= held_reg) begin
                                if (!has_applied_reg || req != held_reg) begin
                                    last_temp_next = t_reg;
                                end
                                has_applied_next = 1'b1;
                                held_next        = req;
                            end else if (({1'b0, t_reg} + {1'b0, hyst, 4'd0})
                                         <= {1'b0, last_temp_reg}) begin
                                last_temp_next = t_reg;
                                held_next      = req;
                            end else begin
                                app        = held_reg;
                                hold       = 1'b1;
                                reason_out = fchc_pkg::REASON_HOLD;
                            end
                        end
                    endcase
                    m_tdata_next  = {2'b00, app[6:0], req[6:0]};
                    m_tuser_next  = {hold, reason_out, seg_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            has_applied_reg <= 1'b0;
            last_temp_reg   <= '0;
            held_reg        <= '0;
            curve_temps_reg <= fchc_pkg::CURVE_TEMPS_RST;
            curve_fans_reg  <= fchc_pkg::CURVE_FANS_RST;
            min_fan_reg     <= '0;
            hyst_deg_reg    <= '0;
            fallback_reg    <= fchc_pkg::FALLBACK_RST;
            plaus_max_reg   <= fchc_pkg::PLAUSIBLE_RST;
        end else begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            has_applied_reg <= has_applied_next;
            last_temp_reg   <= last_temp_next;
            held_reg        <= held_next;
            if (cfg_we) begin
                case (cfg_addr)
                    fchc_pkg::CFG_CURVE_TEMPS:   curve_temps_reg <= cfg_wdata;
                    fchc_pkg::CFG_CURVE_FANS:    curve_fans_reg  <= cfg_wdata;
                    fchc_pkg::CFG_MIN_FAN_PCT:   min_fan_reg     <= cfg_wdata[7:0];
                    fchc_pkg::CFG_HYSTERESIS:    hyst_deg_reg    <= cfg_wdata[7:0];
                    fchc_pkg::CFG_FALLBACK_PCT:  fallback_reg    <= cfg_wdata[6:0];
                    fchc_pkg::CFG_PLAUSIBLE_MAX: plaus_max_reg   <= cfg_wdata[11:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        t_reg       <= t_next;
        ok_reg      <= ok_next;
        idx_reg     <= idx_next;
        seg_reg     <= seg_next;
        reason_reg  <= reason_next;
        pct_reg     <= pct_next;
        den_reg     <= den_next;
        off_reg     <= off_next;
        p0_reg      <= p0_next;
        dp_reg      <= dp_next;
        acc_reg     <= acc_next;
        div_reg     <= div_next;
        k_reg       <= k_next;
        q_reg       <= q_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // partial remainder stays below twice the shifted divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> acc_reg < ({8'd0, div_reg, 1'b0} << k_reg))
        else $error("divider remainder out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !has_applied_reg |-> (last_temp_reg == '0 && held_reg == '0))
        else $error("hysteresis state not cleared");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tuser_reg[7] == (m_tuser_reg[6:4] == fchc_pkg::REASON_HOLD)))
        else $error("holding flag disagrees with reason");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_tuser_reg[6:4] == fchc_pkg::REASON_INVALID ||
                         m_tuser_reg[6:4] == fchc_pkg::REASON_IMPLAUSIBLE)
        |-> m_tuser_reg[3:0] == fchc_pkg::SEG_NONE)
        else $error("segment set on a non-curve result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted while busy");

endmodule

/* bench/tb_fan_curve_hysteresis_controller.sv */
module tb_fan_curve_hysteresis_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINTS    = 4;
    localparam int FULL_DUTY = 100;
    localparam int HYST_CAP  = 10;

    typedef struct packed {
        logic [fchc_pkg::PCT_W-1:0] requested;
        logic [fchc_pkg::PCT_W-1:0] applied;
        logic [fchc_pkg::SEG_W-1:0] segment;
        fchc_pkg::reason_t          reason;
        logic                       holding;
    } duty_beat_t;

    class fan_duty_scoreboard;
        logic [31:0] temps;
        logic [31:0] fans;
        logic [7:0]  min_pct;
        logic [7:0]  hyst_deg;
        logic [6:0]  fallback;
        logic [11:0] plaus_max;
        bit          applied_valid;
        int          last_temp;
        int          held;
        duty_beat_t  pending[$];
        int          errors;

        function new();
            temps         = fchc_pkg::CURVE_TEMPS_RST;
            fans          = fchc_pkg::CURVE_FANS_RST;
            min_pct       = 8'd0;
            hyst_deg      = 8'd0;
            fallback      = fchc_pkg::FALLBACK_RST;
            plaus_max     = fchc_pkg::PLAUSIBLE_RST;
            applied_valid = 1'b0;
            last_temp     = 0;
            held          = 0;
            errors        = 0;
        endfunction

        function void write_reg(logic [fchc_pkg::CFG_AW-1:0] idx,
                                logic [fchc_pkg::CFG_DW-1:0] val);
            case (idx)
                fchc_pkg::CFG_CURVE_TEMPS:   temps = val;
                fchc_pkg::CFG_CURVE_FANS:    fans = val;
                fchc_pkg::CFG_MIN_FAN_PCT:   min_pct = val[7:0];
                fchc_pkg::CFG_HYSTERESIS:    hyst_deg = val[7:0];
                fchc_pkg::CFG_FALLBACK_PCT:  fallback = val[6:0];
                fchc_pkg::CFG_PLAUSIBLE_MAX: plaus_max = val[11:0];
                default: ;
            endcase
        endfunction

        function int point_temp(int i);
            if (i < 0 || i > 3) return 0;
            return int'(temps[8*i +: 8]);
        endfunction

        function int point_fan(int i);
            if (i < 0 || i > 3) return 0;
            return int'(fans[8*i +: 8]);
        endfunction

        function int curve_duty(int t, output int seg);
            int     minp;
            int     pct;
            longint t0, t1, p0, p1, den, num, v;
            minp = (min_pct > FULL_DUTY) ? FULL_DUTY : int'(min_pct);
            if (t < 16 * point_temp(0)) begin
                seg = 0;
                pct = point_fan(0);
            end else if (t >= 16 * point_temp(POINTS - 1)) begin
                seg = POINTS;
                pct = point_fan(POINTS - 1);
            end else begin
                seg = 1;
                pct = point_fan(0);
                for (int i = 1; i < POINTS; i++) begin
                    if (t < 16 * point_temp(i)) begin
                        t0  = point_temp(i - 1);
                        t1  = point_temp(i);
                        p0  = point_fan(i - 1);
                        p1  = point_fan(i);
                        den = 16 * (t1 - t0);
                        num = (longint'(t) - 16 * t0) * (p1 - p0);
                        v   = 2 * p0 * den + 2 * num + den;
                        if (den <= 0 || v < 0) pct = 0;
                        else pct = int'(v / (2 * den));
                        seg = i;
                        break;
                    end
                end
            end
            if (pct < minp) pct = minp;
            if (pct > FULL_DUTY) pct = FULL_DUTY;
            return pct;
        endfunction

        function void note_sample(logic [fchc_pkg::TEMP_W-1:0] t_in, logic ok);
            int                t, req, app, seg, hyst;
            fchc_pkg::reason_t why;
            logic              hold;
            duty_beat_t        e;
            t    = int'(t_in);
            seg  = -1;
            hold = 1'b0;
            hyst = (hyst_deg > HYST_CAP) ? HYST_CAP : int'(hyst_deg);
            if (!ok || t == 0) begin
                applied_valid = 1'b0;
                last_temp     = 0;
                held          = 0;
                req           = int'(fallback);
                app           = req;
                why           = fchc_pkg::REASON_INVALID;
            end else if (t > int'(plaus_max)) begin
                req           = FULL_DUTY;
                app           = FULL_DUTY;
                why           = fchc_pkg::REASON_IMPLAUSIBLE;
                applied_valid = 1'b1;
                last_temp     = t;
                held          = FULL_DUTY;
            end else begin
                req = curve_duty(t, seg);
                if (seg == 0) why = fchc_pkg::REASON_BELOW;
                else if (seg >= POINTS) why = fchc_pkg::REASON_ABOVE;
                else why = fchc_pkg::REASON_ACTIVE;
                if (!applied_valid || req >= held) begin
                    if (!applied_valid || req != held) last_temp = t;
                    applied_valid = 1'b1;
                    held          = req;
                    app           = req;
                end else if (t <= last_temp - 16 * hyst) begin
                    last_temp = t;
                    held      = req;
                    app       = req;
                end else begin
                    app  = held;
                    hold = 1'b1;
                    why  = fchc_pkg::REASON_HOLD;
                end
            end
            e.requested = req[fchc_pkg::PCT_W-1:0];
            e.applied   = app[fchc_pkg::PCT_W-1:0];
            e.segment   = seg[fchc_pkg::SEG_W-1:0];
            e.reason    = why;
            e.holding   = hold;
            pending.push_back(e);
        endfunction

        task report(string what, int got, int want);
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_beat(logic [15:0] data, logic [7:0] user);
            duty_beat_t e;
            if (pending.size() == 0) begin
                report("unexpected beat", int'(data), -1);
                return;
            end
            e = pending.pop_front();
            if (data[6:0] != e.requested)
                report("req_duty", int'(data[6:0]), int'(e.requested));
            if (data[13:7] != e.applied)
                report("drv_duty", int'(data[13:7]), int'(e.applied));
            if (user[3:0] != e.segment)
                report("segment", int'(user[3:0]), int'(e.segment));
            if (user[6:4] != e.reason)
                report("reason", int'(user[6:4]), int'(e.reason));
            if (user[7] != e.holding)
                report("holding", int'(user[7]), int'(e.holding));
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   s_tdata;
    logic [0:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [15:0]                   m_tdata;
    logic [7:0]                    m_tuser;
    logic                          cfg_we;
    logic [fchc_pkg::CFG_AW-1:0]   cfg_addr;
    logic [fchc_pkg::CFG_DW-1:0]   cfg_wdata;

    fan_duty_scoreboard sb = new();
    bit                 steady;
    bit                 rx_hold_req;
    int                 walk_temp;

    fan_curve_hysteresis_controller #(
        .CURVE_POINTS(POINTS),
        .FAN_MAX_PCT (FULL_DUTY),
        .HYST_MAX_DEG(HYST_CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [12:0] next_probe();
        int   r, t;
        logic ok;
        r  = $urandom_range(0, 99);
        ok = 1'b1;
        if (r < 4) begin
            ok = 1'b0;
            t  = $urandom_range(0, 4095);
        end else if (r < 7) begin
            t = 0;
        end else if (r < 12) begin
            t = $urandom_range(0, 4095);
        end else if (r < 16) begin
            t = int'(sb.plaus_max) + int'($urandom_range(0, 8)) - 4;
        end else begin
            if (r < 24)
                walk_temp = 16 * sb.point_temp($urandom_range(0, POINTS - 1))
                          + int'($urandom_range(0, 8)) - 4;
            else
                walk_temp = walk_temp + int'($urandom_range(0, 96)) - 48;
            if (walk_temp < 1) walk_temp = 1;
            if (walk_temp > 4095) walk_temp = 4095;
            t = walk_temp;
        end
        if (t < 0) t = 0;
        if (t > 4095) t = 4095;
        return {ok, t[11:0]};
    endfunction

    task automatic send_sample(input logic [fchc_pkg::TEMP_W-1:0] t, input logic ok);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, t};
        s_tuser  = ok;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(t, ok);
    endtask

    task automatic sender_gap();
        int n;
        n = steady ? 0 : pick_gap();
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [fchc_pkg::CFG_AW-1:0] idx,
                             input logic [fchc_pkg::CFG_DW-1:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        sb.write_reg(idx, val);
    endtask

    task automatic end_cfg();
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic configure_phase(input int p);
        logic [31:0] temps_v, fans_v;
        int          t, f, min_v, hyst_v, fb_v, plaus_v;
        t = $urandom_range(0, 80);
        f = $urandom_range(0, 60);
        for (int k = 0; k < 4; k++) begin
            temps_v[8*k +: 8] = t[7:0];
            fans_v[8*k +: 8]  = f[7:0];
            t = t + $urandom_range(1, 50);
            f = f + $urandom_range(0, 30);
            if (t > 255) t = 255;
            if (f > 100) f = 100;
        end
        min_v   = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 255) : $urandom_range(0, 60);
        hyst_v  = $urandom_range(0, 14);
        fb_v    = $urandom_range(0, 100);
        plaus_v = $urandom_range(1200, 4095);
        case (p)
            1: begin
                temps_v = '1; fans_v = '1;
                min_v = 255; hyst_v = 255; fb_v = 100; plaus_v = 4095;
            end
            2: begin
                temps_v = '0; fans_v = '0;
                min_v = 0; hyst_v = 0; fb_v = 0; plaus_v = 0;
            end
            5: begin
                temps_v = $urandom;
                fans_v  = $urandom;
            end
            default: ;
        endcase
        write_cfg(fchc_pkg::CFG_CURVE_TEMPS, temps_v);
        write_cfg(fchc_pkg::CFG_CURVE_FANS, fans_v);
        write_cfg(fchc_pkg::CFG_MIN_FAN_PCT, min_v);
        write_cfg(fchc_pkg::CFG_HYSTERESIS, hyst_v);
        write_cfg(fchc_pkg::CFG_FALLBACK_PCT, fb_v);
        write_cfg(fchc_pkg::CFG_PLAUSIBLE_MAX, plaus_v);
        end_cfg();
    endtask

    // receive side: random backpressure plus one long hold-off on request
    initial begin
        int quiet;
        int g;
        bit hold_done;
        quiet     = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
            @(negedge aclk);
            if (quiet > 0) begin
                quiet--;
                m_tready = 1'b0;
            end else if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                quiet     = 300;
                m_tready  = 1'b0;
            end else if (steady) begin
                m_tready = 1'b1;
            end else begin
                g = pick_gap();
                if (g == 0) begin
                    m_tready = 1'b1;
                end else begin
                    m_tready = 1'b0;
                    quiet    = g - 1;
                end
            end
        end
    end

    initial begin
        logic [12:0] probes [21];
        logic [12:0] pr;
        probes = '{
            {1'b1, 12'd0},    {1'b0, 12'd500},  {1'b0, 12'd4095}, {1'b1, 12'd4095},
            {1'b1, 12'd2401}, {1'b1, 12'd2400}, {1'b1, 12'd1},    {1'b1, 12'd719},
            {1'b1, 12'd720},  {1'b1, 12'd721},  {1'b1, 12'd831},  {1'b1, 12'd832},
            {1'b1, 12'd900},  {1'b1, 12'd1023}, {1'b1, 12'd1024}, {1'b1, 12'd1000},
            {1'b1, 12'd940},  {1'b1, 12'd800},  {1'b0, 12'd0},    {1'b1, 12'd1020},
            {1'b1, 12'd3000}
        };
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        steady      = 1'b0;
        rx_hold_req = 1'b0;
        walk_temp   = 800;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_cfg(fchc_pkg::CFG_HYSTERESIS, 5);
        end_cfg();
        foreach (probes[i]) begin
            send_sample(probes[i][11:0], probes[i][12]);
            sender_gap();
        end

        for (int p = 1; p <= 8; p++) begin
            drain();
            configure_phase(p);
            steady    = (p == 3);
            walk_temp = 16 * sb.point_temp($urandom_range(0, POINTS - 1)) + 8;
            if (walk_temp < 1) walk_temp = 1;
            if (walk_temp > 4095) walk_temp = 4095;
            for (int n = 0; n < 170; n++) begin
                pr = next_probe();
                send_sample(pr[11:0], pr[12]);
                if (p == 6 && n == 40) rx_hold_req = 1'b1;
                if (p == 4 && n == 80) drain();
                else sender_gap();
            end
        end
        drain();

        if (sb.errors == 0) begin
            $display("tb_fan_curve_hysteresis_controller OK");
        end else begin
            $display("tb_fan_curve_hysteresis_controller NOT OK");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb_fan_curve_hysteresis_controller NOT OK");
        $finish;
    end

endmodule
